// ----- hdl/ostt_pkg.sv -----
`default_nettype none

package ostt_pkg;

  localparam int SLOTS_DEF  = 16;
  localparam int RESULT_CAP = 16;
  localparam int ID_W       = 32;
  localparam int DELAY_W    = 32;
  localparam int EXP_W      = 64;
  localparam int ENTRY_W    = ID_W + EXP_W;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_REG  = 2'd1,
    OP_REM  = 2'd2,
    OP_SCAN = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK,
    ST_REG,
    ST_WALK,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    op_t             kind;
    logic [ID_W-1:0] id;
    logic            ok;
    logic            last;
  } res_t;

endpackage

`default_nettype wire

// ----- hdl/one_shot_timer_table.sv -----
// tick: the tick state loads the result word into the output register once it is free
// register: lowest free slot found by a walk over the valid bits
// remove: one walk over the entry ram (one read per cycle)
// scan: one ram walk per fired timer, plus a closing walk when fewer than 16 fire, up to 16 fired per scan
// a new word is taken once the last result is in the output register
// rst_n (synchronous) empties the table, clears the tick count and sets the next id to 1
`default_nettype none

module one_shot_timer_table #(
  parameter int SLOTS = ostt_pkg::SLOTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // delay[31:0], target_id[63:32]
  input  wire logic [1:0]  in_tuser,   // func[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [39:0] out_tdata,  // timer_id_out[31:0], ok[32], zero[39:33]
  output logic      [1:0]  out_tuser,  // result_kind[1:0]
  output logic             out_tlast
);

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int FW = $clog2(ostt_pkg::RESULT_CAP);
  localparam int IDW = ostt_pkg::ID_W;
  localparam int EXW = ostt_pkg::EXP_W;

  ostt_pkg::state_t state_r, state_nxt;
  ostt_pkg::op_t    op_r, op_nxt;
  logic [ostt_pkg::DELAY_W-1:0] delay_r, delay_nxt;
  logic [IDW-1:0]   rid_r, rid_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             chk_vld_r, chk_vld_nxt;
  logic [IW-1:0]    chk_idx_r, chk_idx_nxt;
  logic [SLOTS-1:0] valid_r, valid_nxt;
  logic [EXW-1:0]   tick_r, tick_nxt;
  logic [IDW-1:0]   nid_r, nid_nxt;
  logic             hit_r, hit_nxt;
  logic [IDW-1:0]   best_id_r, best_id_nxt;
  logic [IW-1:0]    best_idx_r, best_idx_nxt;
  logic             pend_vld_r, pend_vld_nxt;
  logic [IDW-1:0]   pend_id_r, pend_id_nxt;
  logic [FW-1:0]    fired_r, fired_nxt;
  ostt_pkg::res_t   out_res_r, res_emit;
  logic             out_tvalid_r;

  logic                         ram_we;
  logic [ostt_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata;
  logic [IDW-1:0]               rd_ident;
  logic [EXW-1:0]               rd_exp;

  logic          in_acc, out_free, go, need_emit, out_load;
  logic          walk_end, chk_live, rem_match, scan_cand;
  logic [IW-1:0] reg_slot;
  logic          reg_free, reg_last, scan_cap;

  assign in_acc    = in_tvalid && in_tready;
  assign in_tready = (state_r == ostt_pkg::ST_IDLE);
  assign out_free  = !out_tvalid_r || out_tready;

  assign rd_ident = ram_rdata[IDW-1:0];
  assign rd_exp   = ram_rdata[ostt_pkg::ENTRY_W-1:IDW];

  assign walk_end  = (state_r == ostt_pkg::ST_WALK) && (cnt_r == CW'(SLOTS)) && !chk_vld_r;
  assign chk_live  = chk_vld_r && valid_r[chk_idx_r];
  assign rem_match = chk_live && (rd_ident == rid_r);
  // strict less keeps the lower slot on equal ids
  assign scan_cand = chk_live && (rd_exp <= tick_r) && (!hit_r || (rd_ident < best_id_r));
  assign reg_slot  = cnt_r[IW-1:0];
  assign reg_free  = !valid_r[reg_slot];
  assign reg_last  = (cnt_r == CW'(SLOTS - 1));
  assign scan_cap  = (fired_r == FW'(ostt_pkg::RESULT_CAP - 1));

  assign ram_wdata = {tick_r + EXW'(delay_r), nid_r};

  ostt_ram #(
    .WIDTH (ostt_pkg::ENTRY_W),
    .DEPTH (SLOTS)
  ) u_entries (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (reg_slot),
    .wr_data (ram_wdata),
    .rd_addr (cnt_r[IW-1:0]),
    .rd_data (ram_rdata)
  );

  // result word to emit and whether this cycle wants to emit one
  always_comb begin
    need_emit = 1'b0;
    res_emit  = '{kind: op_r, id: '0, ok: 1'b0, last: 1'b1};
    unique case (state_r)
      ostt_pkg::ST_IDLE: begin
        need_emit = 1'b0;
      end
      ostt_pkg::ST_TICK: begin
        need_emit = 1'b1;
        res_emit  = '{kind: ostt_pkg::OP_TICK, id: '0, ok: 1'b1, last: 1'b1};
      end
      ostt_pkg::ST_REG: begin
        need_emit = reg_free || reg_last;
        if (reg_free) begin
          res_emit = '{kind: ostt_pkg::OP_REG, id: nid_r, ok: 1'b1, last: 1'b1};
        end else begin
          res_emit = '{kind: ostt_pkg::OP_REG, id: '0, ok: 1'b0, last: 1'b1};
        end
      end
      ostt_pkg::ST_WALK: begin
        if (op_r == ostt_pkg::OP_REM) begin
          need_emit = walk_end;
          res_emit  = '{kind: ostt_pkg::OP_REM, id: '0, ok: hit_r, last: 1'b1};
        end else if (hit_r) begin
          // a further expired timer exists, so the pending one is not last
          need_emit = walk_end && pend_vld_r;
          res_emit  = '{kind: ostt_pkg::OP_SCAN, id: pend_id_r, ok: 1'b1, last: 1'b0};
        end else begin
          need_emit = walk_end;
          if (pend_vld_r) begin
            res_emit = '{kind: ostt_pkg::OP_SCAN, id: pend_id_r, ok: 1'b1, last: 1'b1};
          end else begin
            res_emit = '{kind: ostt_pkg::OP_SCAN, id: '0, ok: 1'b0, last: 1'b1};
          end
        end
      end
      ostt_pkg::ST_FLUSH: begin
        need_emit = 1'b1;
        res_emit  = '{kind: ostt_pkg::OP_SCAN, id: pend_id_r, ok: 1'b1, last: 1'b1};
      end
      default: begin
        need_emit = 1'b0;
      end
    endcase
  end

  assign go       = !need_emit || out_free;
  assign out_load = need_emit && out_free;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ostt_pkg::ST_IDLE: begin
        if (in_acc) begin
          unique case (ostt_pkg::op_t'(in_tuser))
            ostt_pkg::OP_TICK: state_nxt = ostt_pkg::ST_TICK;
            ostt_pkg::OP_REG:  state_nxt = ostt_pkg::ST_REG;
            default:           state_nxt = ostt_pkg::ST_WALK;
          endcase
        end
      end
      ostt_pkg::ST_TICK: begin
        if (go) state_nxt = ostt_pkg::ST_IDLE;
      end
      ostt_pkg::ST_REG: begin
        if (go && (reg_free || reg_last)) state_nxt = ostt_pkg::ST_IDLE;
      end
      ostt_pkg::ST_WALK: begin
        if (walk_end && go) begin
          if (op_r == ostt_pkg::OP_SCAN && hit_r) begin
            state_nxt = scan_cap ? ostt_pkg::ST_FLUSH : ostt_pkg::ST_WALK;
          end else begin
            state_nxt = ostt_pkg::ST_IDLE;
          end
        end
      end
      ostt_pkg::ST_FLUSH: begin
        if (go) state_nxt = ostt_pkg::ST_IDLE;
      end
      default: state_nxt = ostt_pkg::ST_IDLE;
    endcase
  end

  // datapath and sequencer registers
  always_comb begin
    op_nxt       = op_r;
    delay_nxt    = delay_r;
    rid_nxt      = rid_r;
    cnt_nxt      = cnt_r;
    chk_vld_nxt  = 1'b0;
    chk_idx_nxt  = cnt_r[IW-1:0];
    valid_nxt    = valid_r;
    tick_nxt     = tick_r;
    nid_nxt      = nid_r;
    hit_nxt      = hit_r;
    best_id_nxt  = best_id_r;
    best_idx_nxt = best_idx_r;
    pend_vld_nxt = pend_vld_r;
    pend_id_nxt  = pend_id_r;
    fired_nxt    = fired_r;
    ram_we       = 1'b0;
    unique case (state_r)
      ostt_pkg::ST_IDLE: begin
        if (in_acc) begin
          op_nxt       = ostt_pkg::op_t'(in_tuser);
          delay_nxt    = in_tdata[31:0];
          rid_nxt      = in_tdata[63:32];
          cnt_nxt      = '0;
          hit_nxt      = 1'b0;
          pend_vld_nxt = 1'b0;
          fired_nxt    = '0;
        end
      end
      ostt_pkg::ST_TICK: begin
        if (go) tick_nxt = tick_r + EXW'(1);
      end
      ostt_pkg::ST_REG: begin
        if (go) begin
          if (reg_free) begin
            ram_we              = 1'b1;
            valid_nxt[reg_slot] = 1'b1;
            nid_nxt             = (nid_r == '1) ? IDW'(1) : nid_r + IDW'(1);
          end else if (!reg_last) begin
            cnt_nxt = cnt_r + CW'(1);
          end
        end
      end
      ostt_pkg::ST_WALK: begin
        if (cnt_r != CW'(SLOTS)) begin
          cnt_nxt     = cnt_r + CW'(1);
          chk_vld_nxt = 1'b1;
        end
        if (op_r == ostt_pkg::OP_REM) begin
          if (rem_match) begin
            valid_nxt[chk_idx_r] = 1'b0;
            hit_nxt              = 1'b1;
          end
        end else if (scan_cand) begin
          hit_nxt      = 1'b1;
          best_id_nxt  = rd_ident;
          best_idx_nxt = chk_idx_r;
        end
        // pass over: fire the best entry and start the next pass
        if (walk_end && go && op_r == ostt_pkg::OP_SCAN && hit_r) begin
          valid_nxt[best_idx_r] = 1'b0;
          pend_vld_nxt          = 1'b1;
          pend_id_nxt           = best_id_r;
          fired_nxt             = fired_r + FW'(1);
          cnt_nxt               = '0;
          hit_nxt               = 1'b0;
        end
      end
      ostt_pkg::ST_FLUSH: begin
        pend_vld_nxt = pend_vld_r;
      end
      default: begin
        cnt_nxt = cnt_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ostt_pkg::ST_IDLE;
      cnt_r        <= '0;
      chk_vld_r    <= 1'b0;
      valid_r      <= '0;
      tick_r       <= '0;
      nid_r        <= IDW'(1);
      hit_r        <= 1'b0;
      pend_vld_r   <= 1'b0;
      fired_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      chk_vld_r  <= chk_vld_nxt;
      valid_r    <= valid_nxt;
      tick_r     <= tick_nxt;
      nid_r      <= nid_nxt;
      hit_r      <= hit_nxt;
      pend_vld_r <= pend_vld_nxt;
      fired_r    <= fired_nxt;
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    delay_r    <= delay_nxt;
    rid_r      <= rid_nxt;
    chk_idx_r  <= chk_idx_nxt;
    best_id_r  <= best_id_nxt;
    best_idx_r <= best_idx_nxt;
    pend_id_r  <= pend_id_nxt;
    if (out_load) begin
      out_res_r <= res_emit;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {7'd0, out_res_r.ok, out_res_r.id};
  assign out_tuser  = out_res_r.kind;
  assign out_tlast  = out_res_r.last;

  // a waiting word is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_tvalid_r || out_tready))
    else $error("output word overwritten");

  // id zero is never handed out
  a_nid_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    nid_r != '0)
    else $error("next id is zero");

  // the tick count moves only on a tick
  a_tick_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ostt_pkg::ST_TICK) |=> $stable(tick_r))
    else $error("tick count changed outside a tick");

  // a fired entry leaves the table at the end of its pass
  a_fire_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (walk_end && go && op_r == ostt_pkg::OP_SCAN && hit_r) |=> !valid_r[$past(best_idx_r)])
    else $error("fired entry still valid");

endmodule

`default_nettype wire

// ----- hdl/ostt_ram.sv -----
`default_nettype none

module ostt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ----- bench/timer_table_checker.sv -----
module timer_table_checker #(
  parameter int SLOTS = ostt_pkg::SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [63:0] in_tdata,   // delay[31:0], target_id[63:32]
  input  logic [1:0]  in_tuser,   // func[1:0]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,  // timer_id_out[31:0], ok[32], zero[39:33]
  input  logic [1:0]  out_tuser,  // result_kind[1:0]
  input  logic        out_tlast,
  output int          mismatches,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // shadow copy of the timer table
  logic                       live     [SLOTS];
  logic [ostt_pkg::ID_W-1:0]  owner_id [SLOTS];
  logic [ostt_pkg::EXP_W-1:0] due_at   [SLOTS];
  logic [ostt_pkg::EXP_W-1:0] ticks;
  logic [ostt_pkg::ID_W-1:0]  next_id;

  ostt_pkg::res_t awaited_results[$];

  function automatic ostt_pkg::res_t make_res(ostt_pkg::op_t k, logic [ostt_pkg::ID_W-1:0] id,
                                              logic ok, logic last);
    ostt_pkg::res_t r;
    r.kind = k;
    r.id   = id;
    r.ok   = ok;
    r.last = last;
    return r;
  endfunction

  task automatic advance_timer_table(input ostt_pkg::op_t op,
                                     input logic [ostt_pkg::DELAY_W-1:0] dly,
                                     input logic [ostt_pkg::ID_W-1:0] rid);
    bit due_now [SLOTS];
    int free_slot;
    int best;
    int n_due;
    int n_fire;
    bit hit;
    free_slot = -1;
    hit = 1'b0;
    n_due = 0;
    case (op)
      ostt_pkg::OP_TICK: begin
        ticks = ticks + 64'd1;
        awaited_results.push_back(make_res(ostt_pkg::OP_TICK, '0, 1'b1, 1'b1));
      end
      ostt_pkg::OP_REG: begin
        for (int i = SLOTS - 1; i >= 0; i--) if (!live[i]) free_slot = i;
        if (free_slot < 0) begin
          awaited_results.push_back(make_res(ostt_pkg::OP_REG, '0, 1'b0, 1'b1));
        end else begin
          live[free_slot]     = 1'b1;
          owner_id[free_slot] = next_id;
          due_at[free_slot]   = ticks + {32'd0, dly};
          awaited_results.push_back(make_res(ostt_pkg::OP_REG, next_id, 1'b1, 1'b1));
          next_id = (next_id == 32'hFFFF_FFFF) ? 32'd1 : next_id + 32'd1;
        end
      end
      ostt_pkg::OP_REM: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (live[i] && owner_id[i] == rid) begin
            live[i] = 1'b0;
            hit = 1'b1;
          end
        end
        awaited_results.push_back(make_res(ostt_pkg::OP_REM, '0, hit, 1'b1));
      end
      ostt_pkg::OP_SCAN: begin
        for (int i = 0; i < SLOTS; i++) begin
          due_now[i] = live[i] && (due_at[i] <= ticks);
          if (due_now[i]) n_due++;
        end
        n_fire = (n_due > ostt_pkg::RESULT_CAP) ? ostt_pkg::RESULT_CAP : n_due;
        if (n_fire == 0)
          awaited_results.push_back(make_res(ostt_pkg::OP_SCAN, '0, 1'b0, 1'b1));
        for (int k = 0; k < n_fire; k++) begin
          best = -1;
          // strict compare keeps equal ids in slot order
          for (int i = 0; i < SLOTS; i++) begin
            if (due_now[i] && (best < 0 || owner_id[i] < owner_id[best])) best = i;
          end
          due_now[best] = 1'b0;
          live[best] = 1'b0;
          awaited_results.push_back(make_res(ostt_pkg::OP_SCAN, owner_id[best], 1'b1,
                                             k == n_fire - 1));
        end
      end
    endcase
  endtask

  always @(posedge clk) begin : watch
    ostt_pkg::res_t want;
    int errs;
    errs = 0;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        live[i] = 1'b0;
        owner_id[i] = '0;
        due_at[i] = '0;
      end
      ticks = '0;
      next_id = 32'd1;
      awaited_results.delete();
      mismatches <= 0;
    end else begin
      if (in_tvalid && in_tready)
        advance_timer_table(ostt_pkg::op_t'(in_tuser), in_tdata[31:0], in_tdata[63:32]);
      if (out_tvalid && out_tready) begin
        if (awaited_results.size() == 0) begin
          $error("result word with none expected: kind %0d id %0d ok %0b last %0b",
                 out_tuser, out_tdata[31:0], out_tdata[32], out_tlast);
          errs++;
        end else begin
          want = awaited_results.pop_front();
          if (out_tuser !== want.kind) begin
            $error("result_kind: expected %0d, got %0d", want.kind, out_tuser);
            errs++;
          end
          if (out_tdata[31:0] !== want.id) begin
            $error("timer_id_out: expected %0d, got %0d", want.id, out_tdata[31:0]);
            errs++;
          end
          if (out_tdata[32] !== want.ok) begin
            $error("ok: expected %0b, got %0b", want.ok, out_tdata[32]);
            errs++;
          end
          if (out_tlast !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_tlast);
            errs++;
          end
          if (out_tdata[39:33] !== 7'd0) begin
            $error("pad: expected 0, got %0h", out_tdata[39:33]);
            errs++;
          end
        end
      end
      mismatches <= mismatches + errs;
    end
    pending <= awaited_results.size();
  end

endmodule

// ----- bench/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEMS = 410;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;   // delay[31:0], target_id[63:32]
  logic [1:0]  in_tuser;   // func[1:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // timer_id_out[31:0], ok[32], zero[39:33]
  logic [1:0]  out_tuser;  // result_kind[1:0]
  logic        out_tlast;

  int mismatches;
  int pending;
  int sent_items;
  int sent_regs;
  int stall_left;
  bit calm;

  one_shot_timer_table DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  timer_table_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

  // mostly short pauses, now and then a long one; none while calm
  function automatic int pause_len();
    int roll;
    roll = $urandom_range(0, 9);
    if (calm) return 0;
    if (roll < 6) return $urandom_range(0, 2);
    if (roll < 9) return $urandom_range(3, 6);
    return $urandom_range(15, 40);
  endfunction

  // output back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (calm) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(0, 3) != 0);
      stall_left <= pause_len();
    end
  end

  task automatic send_word(input ostt_pkg::op_t op, input logic [31:0] dly,
                           input logic [31:0] tid);
    int gap;
    gap = pause_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      in_tdata  <= {$urandom, $urandom};
      in_tuser  <= 2'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {tid, dly};
    do @(posedge clk); while (!in_tready);
    sent_items++;
    if (op == ostt_pkg::OP_REG) sent_regs++;
  endtask

  // an id near the newest one handed out, or anywhere among the issued ones
  function automatic logic [31:0] recent_id(int span);
    int lo;
    if (sent_regs == 0) return 32'd1;
    lo = (span == 0 || sent_regs <= span) ? 1 : sent_regs - span;
    return 32'($urandom_range(lo, sent_regs));
  endfunction

  function automatic logic [31:0] short_delay();
    if ($urandom_range(0, 31) == 0) return $urandom;
    return 32'($urandom_range(0, 8));
  endfunction

  initial begin
    int pattern;
    int n;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= ostt_pkg::OP_TICK;
    calm        = 1'b0;
    sent_items  = 0;
    sent_regs   = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // scan and removes on an empty table
    send_word(ostt_pkg::OP_SCAN, $urandom, $urandom);
    send_word(ostt_pkg::OP_REM, $urandom, 32'd0);
    send_word(ostt_pkg::OP_REM, $urandom, 32'hFFFF_FFFF);
    send_word(ostt_pkg::OP_REG, 32'd0, $urandom);
    send_word(ostt_pkg::OP_REG, 32'hFFFF_FFFF, $urandom);
    send_word(ostt_pkg::OP_REG, 32'd1, $urandom);
    send_word(ostt_pkg::OP_TICK, $urandom, $urandom);
    send_word(ostt_pkg::OP_SCAN, $urandom, $urandom);
    // fill up, one more register while full, then a big scan
    repeat (15) send_word(ostt_pkg::OP_REG, 32'd0, $urandom);
    send_word(ostt_pkg::OP_REG, 32'd0, $urandom);
    send_word(ostt_pkg::OP_SCAN, $urandom, $urandom);
    send_word(ostt_pkg::OP_REM, $urandom, 32'd2);
    send_word(ostt_pkg::OP_REM, $urandom, 32'd2);

    while (sent_items < ITEMS) begin
      calm = ($urandom_range(0, 5) == 0);
      pattern = $urandom_range(0, 9);
      if (pattern < 6) begin
        n = $urandom_range(1, 5);
        repeat (n) send_word(ostt_pkg::OP_REG, short_delay(), $urandom);
        n = $urandom_range(0, 6);
        repeat (n) send_word(ostt_pkg::OP_TICK, $urandom, $urandom);
        if ($urandom_range(0, 2) == 0) send_word(ostt_pkg::OP_REM, $urandom, recent_id(8));
        send_word(ostt_pkg::OP_SCAN, $urandom, $urandom);
      end else if (pattern < 8) begin
        n = $urandom_range(1, 3);
        repeat (n) begin
          case ($urandom_range(0, 3))
            0: send_word(ostt_pkg::OP_TICK, $urandom, $urandom);
            1: send_word(ostt_pkg::OP_REG, short_delay(), $urandom);
            2: send_word(ostt_pkg::OP_REM, $urandom, $urandom);
            default: send_word(ostt_pkg::OP_SCAN, $urandom, $urandom);
          endcase
        end
      end else if (pattern == 8) begin
        // fill the table so that a scan fires many timers at once
        n = $urandom_range(12, 18);
        repeat (n) send_word(ostt_pkg::OP_REG, 32'($urandom_range(0, 3)), $urandom);
        n = $urandom_range(0, 4);
        repeat (n) send_word(ostt_pkg::OP_TICK, $urandom, $urandom);
        send_word(ostt_pkg::OP_SCAN, $urandom, $urandom);
      end else begin
        n = $urandom_range(1, 3);
        repeat (n) send_word(ostt_pkg::OP_REM, $urandom, recent_id(0));
        send_word(ostt_pkg::OP_REM, $urandom, recent_id(4));
      end
    end

    calm = 1'b0;
    in_tvalid <= 1'b0;
    @(posedge clk);
    n = 0;
    while (pending != 0 && n < 20000) begin
      @(posedge clk);
      n++;
    end
    if (pending != 0) begin
      $display("Mismatches found");
      $finish;
    end else begin
      repeat (400) @(posedge clk);
      if (mismatches == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
    end
  end

endmodule
